// ===== design/wcft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character-class functions for the word class tagger.
// No dependencies; every other design file imports this package.
package wcft_pkg;

  // Field widths
  localparam int CP_W     = 21;
  localparam int IDX_W    = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Suffix ROM
  localparam int ROM_DEPTH    = 190;
  localparam int SUFFIX_COUNT = 190;

  // Register map: register index taken from paddr[2]
  localparam logic REG_REDUCED_MODE = 1'b0;

  // ASCII characters the number scanner recognizes
  localparam logic [CP_W-1:0] CH_PLUS  = 21'h00002b;
  localparam logic [CP_W-1:0] CH_MINUS = 21'h00002d;
  localparam logic [CP_W-1:0] CH_DOT   = 21'h00002e;
  localparam logic [CP_W-1:0] CH_0     = 21'h000030;
  localparam logic [CP_W-1:0] CH_9     = 21'h000039;
  localparam logic [CP_W-1:0] CH_UP_D  = 21'h000044;
  localparam logic [CP_W-1:0] CH_UP_E  = 21'h000045;
  localparam logic [CP_W-1:0] CH_LO_D  = 21'h000064;
  localparam logic [CP_W-1:0] CH_LO_E  = 21'h000065;
  localparam logic [CP_W-1:0] CH_MAX_NARROW = 21'h0000ff;

  // Full-width digits zero to nine
  localparam logic [CP_W-1:0] FW_DIGIT_LO = 21'h00ff10;
  localparam logic [CP_W-1:0] FW_DIGIT_HI = 21'h00ff19;

  typedef enum logic [1:0] {
    CLASS_NUMBER  = 2'd0,
    CLASS_CHINESE = 2'd1,
    CLASS_OTHER   = 2'd2
  } word_class_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_char;
  } in_item_t;

  typedef struct packed {
    word_class_t      word_class;
    logic [IDX_W-1:0] suffix_index;
  } out_item_t;

  localparam logic [CP_W-1:0] SUFFIX_ROM [ROM_DEPTH] = '{
    21'h4ebf,21'h4e07,21'h5e74,21'h591a,21'h65e5,21'h6027,21'h4f1a,21'h4e1a,21'h56fd,21'h4e94,
    21'h4e00,21'h56db,21'h90e8,21'h5316,21'h516d,21'h4e8c,21'h4e09,21'h5e02,21'h957f,21'h4eba,
    21'h4e5d,21'h533a,21'h516b,21'h4e03,21'h51fa,21'h529b,21'h4e8e,21'hff10,21'h5341,21'h961f,
    21'h6cd5,21'h673a,21'h5382,21'h5730,21'h91cf,21'h5230,21'h5c14,21'h8005,21'h989d,21'h5c40,
    21'h6e2f,21'h5165,21'h5bb6,21'h5236,21'h54c1,21'h7701,21'h70b9,21'h4e9a,21'h6708,21'h578b,
    21'h5ea6,21'h9762,21'h65b9,21'h7387,21'h65af,21'h754c,21'h5458,21'h519b,21'h5c71,21'h4e0a,
    21'h8d44,21'h5934,21'h6743,21'h5dde,21'h751f,21'h7ebf,21'h8d5b,21'h4eec,21'h5de5,21'h6d77,
    21'h514b,21'h62a5,21'h5357,21'h4f59,21'h767e,21'h5e73,21'h5b50,21'h4ea7,21'h5b66,21'h91d1,
    21'h592b,21'h534e,21'h5149,21'h5546,21'h8fbe,21'h56e2,21'h7ea7,21'h6b3e,21'h573a,21'h503c,
    21'h8f66,21'h52a1,21'h58eb,21'h4e49,21'h53e3,21'h5904,21'h5343,21'h7acb,21'h4f5c,21'h4e8b,
    21'hff12,21'h7269,21'h8def,21'h4ef6,21'h6570,21'h6c5f,21'h59d4,21'h5fb7,21'h5173,21'h4e1c,
    21'h5170,21'h8d77,21'h56ed,21'h624b,21'h7ad9,21'h4efd,21'h5f97,21'h529e,21'h5728,21'hff15,
    21'h5f00,21'h6c14,21'h79d1,21'h5408,21'h8fdb,21'h8fd0,21'h7a0e,21'h4efb,21'h80fd,21'h7535,
    21'h8bc1,21'h4f4d,21'h73b0,21'h6d41,21'h6218,21'h80a1,21'h5f0f,21'h8272,21'h793e,21'hff11,
    21'h4ee5,21'h53d6,21'h8bba,21'h5f80,21'h8d39,21'h6599,21'h5206,21'h5b89,21'h5c9b,21'h6587,
    21'h5e08,21'h7279,21'h897f,21'h7ed9,21'h6240,21'h9662,21'h7403,21'h5c5e,21'h5317,21'h6728,
    21'h6625,21'h6c34,21'h671b,21'h57ce,21'h672c,21'h76ee,21'h6b65,21'h6d0b,21'h8282,21'h9a6c,
    21'h5883,21'h53d8,21'hff16,21'h4e66,21'h5e26,21'h7a7a,21'h4e16,21'h5385,21'h4ef7,21'h826f,
    21'h6536,21'h95f4,21'h662f,21'h6c47,21'h8ba1,21'h53d7,21'h75c5,21'h8425,21'h9500,21'h53bb
  };

  // Chinese digit: full-width digits and the listed numeral characters
  function automatic logic han_digit(input logic [CP_W-1:0] c);
    logic hit;
    hit = (c >= FW_DIGIT_LO) && (c <= FW_DIGIT_HI);
    case (c)
      21'h4ebf, 21'h4e07, 21'h5343, 21'h767e, 21'h5341, 21'h4e00, 21'h4e8c,
      21'h4e09, 21'h56db, 21'h4e94, 21'h516d, 21'h4e03, 21'h516b, 21'h4e5d: hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  // Characters allowed inside a Chinese numeral word besides digits
  function automatic logic han_helper(input logic [CP_W-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      21'h96f6, 21'h4e24, 21'h70b9, 21'h591a,
      21'h4f59, 21'h30fb, 21'h5206, 21'h4e4b: hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

endpackage

// ===== design/wcft_suffix_rom.sv =====
`timescale 1ns / 1ps
// Suffix ROM search: parallel compare of one code point against the suffix table.
// Depends on wcft_pkg for the table and widths.
module wcft_suffix_rom #(
  parameter int SuffixCount = wcft_pkg::SUFFIX_COUNT
) (
  input  logic [wcft_pkg::CP_W-1:0]  code_point,
  output logic [wcft_pkg::IDX_W-1:0] match_index
);
  import wcft_pkg::*;

  // Compare against every entry; the lowest matching entry wins
  always_comb begin
    match_index = '0;
    for (int i = ROM_DEPTH - 1; i >= 0; i--) begin
      if ((i < SuffixCount) && (SUFFIX_ROM[i] == code_point)) begin
        match_index = IDX_W'(i + 1);
      end
    end
  end

endmodule

// ===== design/word_class_feature_tagger.sv =====
`timescale 1ns / 1ps
// Word class tagger top level: input register, per-word scan flags, result register.
// Depends on wcft_pkg and wcft_suffix_rom.
// A word's result reaches out_valid via the input register, then the result register.
// Throughput: one character per cycle; input stalls only while a final character waits
// behind a held result. Reset (rst, synchronous): clears both stages, flags and reduced_mode.
module word_class_feature_tagger #(
  parameter int SuffixCount = wcft_pkg::SUFFIX_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wcft_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wcft_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wcft_pkg::ADDR_W-1:0] paddr,
  input  logic [wcft_pkg::DATA_W-1:0] pwdata,
  output logic [wcft_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import wcft_pkg::*;

  // Configuration register
  logic reduced_mode;

  // Input stage
  logic     s1_valid;
  in_item_t s1_data;
  logic     advance;

  // Per-word scan state
  logic [1:0] char_count;
  logic       ascii_number_ok, ascii_digit_seen, prev_was_ascii_digit;
  logic       han_number_ok, han_digit_seen, wide_char_seen;

  logic [1:0] char_count_next;
  logic       ascii_number_ok_next, ascii_digit_seen_next, prev_was_ascii_digit_next;
  logic       han_number_ok_next, han_digit_seen_next, wide_char_seen_next;

  // Scan helpers
  logic [CP_W-1:0]  c;
  logic             first, is_digit, pending_exponent, is_number;
  logic [IDX_W-1:0] rom_index;
  out_item_t        result;

  // APB register access
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduced_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_REDUCED_MODE)) begin
      reduced_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_REDUCED_MODE) begin
      prdata[0] = reduced_mode;
    end
  end

  // Advance the input stage unless a result must wait behind a stalled one
  assign advance  = s1_valid && (!s1_data.last_char || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // Suffix lookup on the current character
  wcft_suffix_rom #(
    .SuffixCount(SuffixCount)
  ) u_suffix_rom (
    .code_point (s1_data.code_point),
    .match_index(rom_index)
  );

  // Scan one character and form the word result on the final one
  always_comb begin
    c        = s1_data.code_point;
    first    = (char_count == 2'd0);
    is_digit = (c >= CH_0) && (c <= CH_9);

    pending_exponent      = 1'b0;
    ascii_number_ok_next  = ascii_number_ok;
    ascii_digit_seen_next = ascii_digit_seen;
    priority if (first && ((c == CH_PLUS) || (c == CH_MINUS))) begin
      // leading sign
    end else if (is_digit) begin
      ascii_digit_seen_next = 1'b1;
    end else if (c == CH_DOT) begin
      // dot anywhere
    end else if (((c == CH_LO_E) || (c == CH_UP_E)) && !first && prev_was_ascii_digit) begin
      pending_exponent = 1'b1;
    end else if (((c == CH_LO_D) || (c == CH_UP_D)) && s1_data.last_char) begin
      // final d
    end else begin
      ascii_number_ok_next = 1'b0;
    end
    prev_was_ascii_digit_next = is_digit;

    han_number_ok_next  = han_number_ok;
    han_digit_seen_next = han_digit_seen;
    if (han_digit(c)) begin
      han_digit_seen_next = 1'b1;
    end else if (!han_helper(c)) begin
      han_number_ok_next = 1'b0;
    end

    wide_char_seen_next = wide_char_seen || (c > CH_MAX_NARROW);
    char_count_next     = (char_count == 2'd2) ? char_count : char_count + 2'd1;

    // Word result; an exponent on the final character fails the number test
    is_number = (ascii_number_ok_next && !pending_exponent && ascii_digit_seen_next) ||
                (han_number_ok_next && han_digit_seen_next);
    result.suffix_index = '0;
    if (is_number) begin
      result.word_class = CLASS_NUMBER;
    end else if (wide_char_seen_next) begin
      result.word_class = CLASS_CHINESE;
      if (!first && !reduced_mode) begin
        result.suffix_index = rom_index;
      end
    end else begin
      result.word_class = CLASS_OTHER;
    end
  end

  // Update word state; drop it after the final character
  always_ff @(posedge clk) begin
    if (rst || (advance && s1_data.last_char)) begin
      char_count           <= 2'd0;
      ascii_number_ok      <= 1'b1;
      ascii_digit_seen     <= 1'b0;
      prev_was_ascii_digit <= 1'b0;
      han_number_ok        <= 1'b1;
      han_digit_seen       <= 1'b0;
      wide_char_seen       <= 1'b0;
    end else if (advance) begin
      char_count           <= char_count_next;
      ascii_number_ok      <= ascii_number_ok_next;
      ascii_digit_seen     <= ascii_digit_seen_next;
      prev_was_ascii_digit <= prev_was_ascii_digit_next;
      han_number_ok        <= han_number_ok_next;
      han_digit_seen       <= han_digit_seen_next;
      wide_char_seen       <= wide_char_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_data.last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_data.last_char) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // Input stalls only behind a final character blocked by a held result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_data.last_char && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A suffix index only accompanies a Chinese word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.suffix_index != '0)) |-> (out_data.word_class == CLASS_CHINESE))
    else $error("suffix index on a non-Chinese word");

  // Word state is back at its start values after a result is formed
  assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.last_char) |=>
      (char_count == 2'd0) && ascii_number_ok && han_number_ok && !wide_char_seen)
    else $error("word state not cleared after result");

  // A result register entry never outlives a cycle without stall
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(advance && s1_data.last_char)) |=> !out_valid)
    else $error("result repeated after transfer");
`endif

endmodule
